// ===== design/ssrk_pkg.sv =====
package ssrk_pkg;

  // Field widths fixed by the item format.
  localparam int TextW = 64;
  localparam int YearW = 16;
  localparam int GapW  = 3;

  // One input item.
  typedef struct packed {
    logic [TextW-1:0]        name_text;
    logic [TextW-1:0]        nation_text;
    logic signed [YearW-1:0] founding_year;
    logic                    last_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [TextW-1:0]        out_name;
    logic [TextW-1:0]        out_nation;
    logic signed [YearW-1:0] out_year;
    logic                    last_out;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [TextW-1:0]        name;
    logic [TextW-1:0]        nation;
    logic signed [YearW-1:0] year;
  } rec_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_EXCH,
    OP_SHIFT
  } cell_op_e;

  // Control broadcast from the sequencer to the row of cells.
  typedef struct packed {
    cell_op_e        op;
    logic [GapW-1:0] gap_exp;
    logic            phase;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } sort_state_e;

  // Text up to its first zero byte, within the top nbytes bytes; the rest reads as zero.
  function automatic logic [TextW-1:0] text_key(input logic [TextW-1:0] t, input int nbytes);
    logic [TextW-1:0] k;
    logic             live;
    k    = '0;
    live = 1'b1;
    for (int b = 0; b < TextW / 8; b++) begin
      if (b >= nbytes || t[TextW-1-8*b -: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        k[TextW-1-8*b -: 8] = t[TextW-1-8*b -: 8];
      end
    end
    return k;
  endfunction

  // Strict ordering: name, then nationality, then signed year.
  function automatic logic rec_less(input rec_t a, input rec_t b, input int nbytes);
    logic [TextW-1:0] an;
    logic [TextW-1:0] bn;
    logic [TextW-1:0] aq;
    logic [TextW-1:0] bq;
    logic             lt;
    an = text_key(a.name, nbytes);
    bn = text_key(b.name, nbytes);
    aq = text_key(a.nation, nbytes);
    bq = text_key(b.nation, nbytes);
    if (an != bn) begin
      lt = an < bn;
    end else if (aq != bq) begin
      lt = aq < bq;
    end else begin
      lt = $signed(a.year) < $signed(b.year);
    end
    return lt;
  endfunction

endpackage

// ===== design/ssrk_cell.sv =====
module ssrk_cell #(
  parameter int IDX        = 0,
  parameter int TEXT_BYTES = 8,
  parameter int NUM_GAPS   = 6,
  parameter int CNT_W      = 7
) (
  input  logic              clk_i,
  input  ssrk_pkg::cell_ctl_t ctl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  ssrk_pkg::rec_t    in_rec_i,
  input  ssrk_pkg::rec_t    up_rec_i [NUM_GAPS],
  input  ssrk_pkg::rec_t    dn_rec_i [NUM_GAPS],
  input  logic              dn_swap_i [NUM_GAPS],
  output ssrk_pkg::rec_t    rec_o,
  output logic              swap_o
);
  import ssrk_pkg::*;

  rec_t rec_q;
  rec_t rec_d;
  rec_t up_sel;
  rec_t dn_sel;
  logic dn_swp;
  logic lower;
  logic has_up;
  logic swap;

  // Pick the partners at the current gap and work out this cell's role in the pair.
  always_comb begin
    up_sel = '0;
    dn_sel = '0;
    dn_swp = 1'b0;
    lower  = 1'b0;
    has_up = 1'b0;
    for (int e = 0; e < NUM_GAPS; e++) begin
      if (ctl_i.gap_exp == GapW'(e)) begin
        up_sel = up_rec_i[e];
        dn_sel = dn_rec_i[e];
        dn_swp = dn_swap_i[e];
        lower  = ((((IDX >> e) & 1) == 1) == ctl_i.phase);
        has_up = (IDX + (1 << e)) < int'(count_i);
      end
    end
  end

  // As the lower of a pair, swap when the upper record is strictly smaller.
  assign swap = (ctl_i.op == OP_EXCH) && lower && has_up &&
                rec_less(up_sel, rec_q, TEXT_BYTES);

  // Next content of the cell.
  always_comb begin
    rec_d = rec_q;
    unique case (ctl_i.op)
      OP_LOAD: begin
        if (count_i == CNT_W'(IDX)) begin
          rec_d = in_rec_i;
        end
      end
      OP_EXCH: begin
        if (swap) begin
          rec_d = up_sel;
        end else if (!lower && dn_swp) begin
          rec_d = dn_sel;
        end
      end
      OP_SHIFT: begin
        rec_d = up_rec_i[0];
      end
      default: begin
        rec_d = rec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o  = rec_q;
  assign swap_o = swap;

endmodule

// ===== design/ssrk_ctrl.sv =====
module ssrk_ctrl #(
  parameter int MAX_RECORDS = 64,
  parameter int CNT_W       = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                last_in_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                last_out_o,
  output ssrk_pkg::cell_ctl_t ctl_o,
  output logic [CNT_W-1:0]    count_o
);
  import ssrk_pkg::*;

  sort_state_e      state_q;
  sort_state_e      state_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [GapW-1:0]  pass_q;
  logic [GapW-1:0]  pass_d;
  logic [CNT_W-1:0] round_q;
  logic [CNT_W-1:0] round_d;
  logic [CNT_W-1:0] emit_q;
  logic [CNT_W-1:0] emit_d;
  logic [GapW-1:0]  gap_passes_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             out_last_q;
  logic             out_last_d;

  logic             in_acc;
  logic             out_free;
  logic             store_full;
  logic [GapW-1:0]  cur_exp;
  logic             gap_big;
  logic             last_round;
  logic             last_emit;

  // Shared conditions.
  assign in_acc     = in_valid_i && (state_q == ST_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign store_full = (count_q == CNT_W'(MAX_RECORDS));
  assign cur_exp    = pass_q - GapW'(1);
  assign gap_big    = (int'(cur_exp) >= CNT_W) || ((CNT_W'(1) << cur_exp) >= count_q);
  assign last_round = (round_q == count_q - CNT_W'(1));
  assign last_emit  = (emit_q == count_q - CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && last_in_i) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (pass_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && last_emit) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Counters, cell control and output flags.
  always_comb begin
    count_d       = count_q;
    pass_d        = pass_q;
    round_d       = round_q;
    emit_d        = emit_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_last_d    = out_last_q;
    ctl_o.op      = OP_HOLD;
    ctl_o.gap_exp = cur_exp;
    ctl_o.phase   = round_q[0];
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!store_full) begin
            ctl_o.op = OP_LOAD;
            count_d  = count_q + CNT_W'(1);
          end
          if (last_in_i) begin
            pass_d  = gap_passes_q;
            round_d = '0;
            emit_d  = '0;
          end
        end
      end
      ST_SORT: begin
        if (pass_q != '0) begin
          if (gap_big) begin
            pass_d  = cur_exp;
            round_d = '0;
          end else begin
            ctl_o.op = OP_EXCH;
            if (last_round) begin
              pass_d  = cur_exp;
              round_d = '0;
            end else begin
              round_d = round_q + CNT_W'(1);
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl_o.op    = OP_SHIFT;
          out_valid_d = 1'b1;
          out_last_d  = last_emit;
          emit_d      = emit_q + CNT_W'(1);
          if (last_emit) begin
            count_d = '0;
          end
        end
      end
      default: begin
        ctl_o.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      pass_q       <= '0;
      round_q      <= '0;
      emit_q       <= '0;
      gap_passes_q <= GapW'(2);
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pass_q      <= pass_d;
      round_q     <= round_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      if (cfg_we_i) begin
        gap_passes_q <= cfg_wdata_i;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign last_out_o  = out_last_q;
  assign count_o     = count_q;

`ifndef ASSERT_OFF
  // The fill count never passes the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count above capacity");

  // A sort always works on at least one record.
  a_sort_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (count_q != '0))
    else $error("sorting an empty set");

  // Passes only count down while sorting.
  a_pass_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT && state_d == ST_SORT) |=> (pass_q <= $past(pass_q)))
    else $error("gap pass went up during a sort");

  // Leaving emission empties the store and leaves the final item flagged.
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_LOAD) |=>
      (count_q == '0 && out_valid_q && out_last_q))
    else $error("emission ended without the final item");

  // Compare-exchange only happens while sorting.
  a_exch_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.op == OP_EXCH) |-> (state_q == ST_SORT))
    else $error("exchange outside a sort");
`endif

endmodule

// ===== design/shell_sort_record_key_core.sv =====
// Record sorter. Records are loaded one item per cycle, while input is not stalled, into
// a row of cells, one record per cell, up to MAX_RECORDS; further records of a set are
// dropped. The item flagged last_in starts a Shell sort: for each gap 2^(gap_passes-1)
// down to 1 that is smaller than the record count n, the row runs rounds of odd-even
// compare-exchange between cells a gap apart, while a pass whose gap is not smaller than
// n is skipped. Records are ordered by name, then nationality (unsigned bytes up to the
// first zero byte within TEXT_BYTES), then signed year; equal records keep the order a
// gapped insertion sort gives them. The sorted set then shifts out of the row one item
// per cycle while the output is not stalled, through an output register, the final item
// flagged last_out. Input is stalled from the last_in item until the last result has
// entered the output register. gap_passes must be written only while the block is idle;
// the block itself does not enforce this.
module shell_sort_record_key_core #(
  parameter int MAX_RECORDS = 64,
  parameter int TEXT_BYTES  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssrk_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssrk_pkg::out_item_t out_item_o
);
  import ssrk_pkg::*;

  localparam int CntW    = $clog2(MAX_RECORDS + 1);
  localparam int NumGaps = $clog2(MAX_RECORDS);

  cell_ctl_t       ctl;
  logic [CntW-1:0] count;
  logic            last_out;
  rec_t            in_rec;
  rec_t            cell_rec [MAX_RECORDS];
  logic            cell_swap [MAX_RECORDS];
  rec_t            out_rec_q;

  // Sequencer.
  ssrk_ctrl #(
    .MAX_RECORDS(MAX_RECORDS),
    .CNT_W      (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .last_in_i  (in_item_i.last_in),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .last_out_o (last_out),
    .ctl_o      (ctl),
    .count_o    (count)
  );

  // Incoming record.
  assign in_rec.name   = in_item_i.name_text;
  assign in_rec.nation = in_item_i.nation_text;
  assign in_rec.year   = in_item_i.founding_year;

  // Row of cells, each wired to its partners at every power-of-two distance.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t up_rec [NumGaps];
    rec_t dn_rec [NumGaps];
    logic dn_swap [NumGaps];

    for (genvar e = 0; e < NumGaps; e++) begin : g_gap
      if (i + (1 << e) < MAX_RECORDS) begin : g_up
        assign up_rec[e] = cell_rec[i + (1 << e)];
      end else begin : g_no_up
        assign up_rec[e] = '0;
      end
      if (i >= (1 << e)) begin : g_dn
        assign dn_rec[e]  = cell_rec[i - (1 << e)];
        assign dn_swap[e] = cell_swap[i - (1 << e)];
      end else begin : g_no_dn
        assign dn_rec[e]  = '0;
        assign dn_swap[e] = 1'b0;
      end
    end

    ssrk_cell #(
      .IDX       (i),
      .TEXT_BYTES(TEXT_BYTES),
      .NUM_GAPS  (NumGaps),
      .CNT_W     (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .count_i  (count),
      .in_rec_i (in_rec),
      .up_rec_i (up_rec),
      .dn_rec_i (dn_rec),
      .dn_swap_i(dn_swap),
      .rec_o    (cell_rec[i]),
      .swap_o   (cell_swap[i])
    );
  end

  // Output register takes the head of the row as the row shifts.
  always_ff @(posedge clk_i) begin
    if (ctl.op == OP_SHIFT) begin
      out_rec_q <= cell_rec[0];
    end
  end

  assign out_item_o.out_name   = out_rec_q.name;
  assign out_item_o.out_nation = out_rec_q.nation;
  assign out_item_o.out_year   = out_rec_q.year;
  assign out_item_o.last_out   = last_out;

endmodule

// ===== tb/shell_sort_record_key_core_test.sv =====
`timescale 1ns / 100ps

module shell_sort_record_key_core_test;
  import ssrk_pkg::*;

  localparam int StoreDepth   = 64;
  localparam int MaxIdle      = 8;
  localparam int SettleCycles = 16;
  localparam int QuietLimit   = 4000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [GapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_item_t        in_item_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_item_t       out_item_o;

  // Predicted contents of the record row and the current pass setting.
  rec_t            held_records [StoreDepth];
  int              held_count   = 0;
  logic [GapW-1:0] gap_passes   = 3'd2;
  out_item_t       sorted_expect_q [$];

  int          error_count     = 0;
  int          quiet_cycles    = 0;
  int          records_sent    = 0;
  bit          sender_idles    = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left      = 0;

  shell_sort_record_key_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sort key of a text: its bytes up to the first zero byte, the rest cleared.
  function automatic logic [TextW-1:0] order_key(input logic [TextW-1:0] text);
    logic [TextW-1:0] key;
    bit               ended;
    key   = '0;
    ended = 1'b0;
    for (int b = TextW / 8 - 1; b >= 0; b--) begin
      if (text[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        key[8*b +: 8] = text[8*b +: 8];
      end
    end
    return key;
  endfunction

  // True when record a must come strictly ahead of record b.
  function automatic bit record_precedes(input rec_t a, input rec_t b);
    logic [TextW-1:0] a_key;
    logic [TextW-1:0] b_key;
    a_key = order_key(a.name);
    b_key = order_key(b.name);
    if (a_key != b_key) begin
      return a_key < b_key;
    end
    a_key = order_key(a.nation);
    b_key = order_key(b.nation);
    if (a_key != b_key) begin
      return a_key < b_key;
    end
    return $signed(a.year) < $signed(b.year);
  endfunction

  // Shell sort of the held records: a gapped insertion sort for each power-of-two gap.
  function automatic void shell_sort_held();
    rec_t moving;
    int   gap;
    int   pos;
    for (int p = int'(gap_passes); p > 0; p--) begin
      gap = 1 << (p - 1);
      for (int s = 0; s < gap && s < held_count; s++) begin
        for (int i = s + gap; i < held_count; i += gap) begin
          moving = held_records[i];
          pos    = i;
          while (pos >= s + gap && record_precedes(moving, held_records[pos - gap])) begin
            held_records[pos] = held_records[pos - gap];
            pos -= gap;
          end
          held_records[pos] = moving;
        end
      end
    end
  endfunction

  // Stores an accepted record and, on the final item of a set, queues the sorted run.
  function automatic void record_accepted(input in_item_t item);
    out_item_t result;
    if (held_count < StoreDepth) begin
      held_records[held_count].name   = item.name_text;
      held_records[held_count].nation = item.nation_text;
      held_records[held_count].year   = item.founding_year;
      held_count++;
    end
    if (item.last_in) begin
      shell_sort_held();
      for (int k = 0; k < held_count; k++) begin
        result.out_name   = held_records[k].name;
        result.out_nation = held_records[k].nation;
        result.out_year   = held_records[k].year;
        result.last_out   = (k == held_count - 1);
        sorted_expect_q.push_back(result);
      end
      held_count = 0;
    end
  endfunction

  function automatic in_item_t make_record(input logic [TextW-1:0] name,
                                           input logic [TextW-1:0] nation,
                                           input int year, input bit last);
    in_item_t item;
    item.name_text     = name;
    item.nation_text   = nation;
    item.founding_year = YearW'(year);
    item.last_in       = last;
    return item;
  endfunction

  // Short texts, all under six characters, so that junk in the low bytes follows a zero.
  function automatic logic [TextW-1:0] pool_text(input int unsigned pick);
    case (pick)
      0:       return 64'h4100_0000_0000_0000;
      1:       return 64'h4142_0000_0000_0000;
      2:       return 64'h4142_4300_0000_0000;
      3:       return 64'h4200_0000_0000_0000;
      4:       return 64'h7A7A_0000_0000_0000;
      default: return 64'h0000_0000_0000_0000;
    endcase
  endfunction

  // Mix of fully random texts, tied short texts, tied texts with junk, and random lengths.
  function automatic logic [TextW-1:0] random_text();
    logic [TextW-1:0] text;
    int               len;
    case ($urandom_range(0, 3))
      0: text = {$urandom, $urandom};
      1: text = pool_text($urandom_range(0, 5));
      2: text = pool_text($urandom_range(0, 5)) | TextW'($urandom_range(0, 16'hFFFF));
      default: begin
        text = '0;
        len  = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) begin
          text[TextW-1-8*b -: 8] = 8'($urandom_range(1, 255));
        end
      end
    endcase
    return text;
  endfunction

  function automatic int random_year();
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: begin
        case ($urandom_range(0, 4))
          0:       return -32768;
          1:       return -1;
          2:       return 0;
          3:       return 1;
          default: return 32767;
        endcase
      end
      default: return int'($urandom_range(0, 4)) - 2;
    endcase
  endfunction

  function automatic in_item_t random_record(input bit last);
    return make_record(random_text(), random_text(), random_year(), last);
  endfunction

  // Offers one item after a random gap and returns once it has been accepted.
  task automatic send_record(input in_item_t item);
    int unsigned idle;
    idle = sender_idles ? $urandom_range(0, MaxIdle) : 0;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    record_accepted(item);
    records_sent++;
  endtask

  // Holds the input back until every expected item has come out and the block is quiet.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_gap_passes(input logic [GapW-1:0] passes);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= passes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_passes  = passes;
  endtask

  // Compares one output item with the oldest expectation, field by field.
  task automatic check_sorted_record(input out_item_t got);
    out_item_t want;
    if (sorted_expect_q.size() == 0) begin
      $display("%0t: unexpected item name=%h nation=%h year=%0d last=%b", $time,
               got.out_name, got.out_nation, $signed(got.out_year), got.last_out);
      error_count++;
    end else begin
      want = sorted_expect_q.pop_front();
      if (got.out_name !== want.out_name) begin
        $display("%0t: out_name expected %h actual %h", $time, want.out_name, got.out_name);
        error_count++;
      end
      if (got.out_nation !== want.out_nation) begin
        $display("%0t: out_nation expected %h actual %h", $time, want.out_nation,
                 got.out_nation);
        error_count++;
      end
      if (got.out_year !== want.out_year) begin
        $display("%0t: out_year expected %0d actual %0d", $time, $signed(want.out_year),
                 $signed(got.out_year));
        error_count++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %b actual %b", $time, want.last_out, got.last_out);
        error_count++;
      end
    end
  endtask

  // Output side: checks each accepted item and then stalls for a random number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_sorted_record(out_item_o);
        stall_left = receiver_stalls ? $urandom_range(0, MaxIdle) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Extreme texts and years, ties that differ only in bytes after a zero, and a lone record.
  // Runs with the pass count left at its reset value.
  task automatic test_ordering_extremes();
    send_record(make_record(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32767, 1'b0));
    send_record(make_record(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, -32768, 1'b0));
    send_record(make_record(64'h0, 64'h0, 0, 1'b0));
    send_record(make_record(64'h0, 64'h0, -1, 1'b0));
    send_record(make_record(64'h4100_00FF_FFFF_FFFF, 64'h5800_0000_0000_0000, 5, 1'b0));
    send_record(make_record(64'h4100_0000_0000_0000, 64'h5800_0000_0000_0000, 5, 1'b0));
    send_record(make_record(64'h4100_0000_0000_0000, 64'h5800_1234_5678_9ABC, -5, 1'b0));
    send_record(make_record(64'h8000_0000_0000_0000, 64'h0100_0000_0000_0000, 1, 1'b0));
    send_record(make_record(64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 0, 1'b0));
    send_record(make_record(64'h0000_0000_0000_0001, 64'h00FF_0000_0000_0000, 0, 1'b1));
    send_record(make_record(64'h5A5A_5A5A_A5A5_A5A5, 64'hA5A5_5A5A_0000_0000, -7, 1'b1));
  endtask

  // With no passes the records must come out in load order.
  task automatic test_zero_passes();
    write_gap_passes(3'd0);
    send_record(make_record(64'h4500_0000_0000_0000, 64'h0, 3, 1'b0));
    send_record(make_record(64'h4400_0000_0000_0000, 64'h0, 2, 1'b0));
    send_record(make_record(64'h4300_0000_0000_0000, 64'h0, 1, 1'b0));
    send_record(make_record(64'h4200_0000_0000_0000, 64'h0, 0, 1'b0));
    send_record(make_record(64'h4100_0000_0000_0000, 64'h0, -1, 1'b1));
  endtask

  // Largest pass count: the early gaps exceed the set size and must do nothing.
  task automatic test_gap_beyond_count();
    write_gap_passes(3'd7);
    for (int r = 0; r < 6; r++) begin
      send_record(make_record(64'h4E41_4D45_0000_0000, 64'h4E00_0000_0000_0000 - r,
                              300 - 100 * r, r == 5));
    end
  endtask

  // More records than the row holds; the surplus, the final item included, is dropped.
  task automatic test_store_full();
    write_gap_passes(3'd6);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    for (int r = 1; r <= StoreDepth + 6; r++) begin
      send_record(random_record(r == StoreDepth + 6));
    end
  endtask

  // Random sets of mostly small size under random pass counts and idling patterns.
  task automatic test_random_sets(input int record_total);
    int set_size;
    int stop_at;
    stop_at = records_sent + record_total;
    while (records_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        write_gap_passes(GapW'($urandom_range(0, 7)));
      end
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      set_size = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      for (int r = 1; r <= set_size; r++) begin
        send_record(random_record(r == set_size));
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ordering_extremes();
    test_zero_passes();
    test_gap_beyond_count();
    test_random_sets(60);
    test_store_full();
    test_random_sets(60);
    wait_for_results();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
